### rtl/bitmap_frame_allocator_assert.svh
// assertion macros for the bitmap frame allocator
// used by the datapath module, no other dependencies
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_IMPLIES(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
// no dependencies; the ctrl, datapath and top files refer to it by scoped names
`default_nettype none

package bfa_pkg;

	localparam int FRAME_W      = 12;
	localparam int COUNT_W      = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;
	// frames that any request can ever reach (13-bit frame numbers)
	localparam int FRAME_SPAN   = 8192;

	localparam logic CMD_ALLOC    = 1'b0;
	localparam logic CMD_FREE     = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOMEM = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LO = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_HI = 1'd1;

	typedef struct packed {
		logic               cmd;
		logic [FRAME_W-1:0] first_frame;
		logic [COUNT_W-1:0] frame_count;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] granted_frame;
		logic               status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_LOCATE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic split;
		logic locate;
		logic scan;
		logic mark;
		logic rsp_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_free;
		logic cnt_zero;
		logic found;
		logic fail;
		logic mark_last;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### rtl/bfa_chan_if.sv
// valid/ready channel carrying one payload struct per transfer
// payload type is a parameter, normally a struct from bfa_pkg
`default_nettype none

interface bfa_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/bfa_ctrl.sv
// sequencing state machine of the bitmap frame allocator
// depends on bfa_pkg for the state, command and status types
`default_nettype none

module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bfa_pkg::dp_sts_t  sts,
	output bfa_pkg::dp_cmd_t  cmd
);

	bfa_pkg::state_t state_q;
	bfa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bfa_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) state_d = bfa_pkg::ST_IDLE;
			end
			bfa_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = bfa_pkg::ST_SPLIT;
				end
			end
			bfa_pkg::ST_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = bfa_pkg::ST_LOCATE;
			end
			bfa_pkg::ST_LOCATE: begin
				cmd.locate = 1'b1;
				if (sts.cnt_zero) state_d = bfa_pkg::ST_DONE;
				else if (sts.is_free) state_d = bfa_pkg::ST_MARK;
				else state_d = bfa_pkg::ST_SCAN;
			end
			bfa_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) state_d = bfa_pkg::ST_MARK;
				else if (sts.fail) state_d = bfa_pkg::ST_DONE;
			end
			bfa_pkg::ST_MARK: begin
				cmd.mark = 1'b1;
				if (sts.mark_last) state_d = bfa_pkg::ST_DONE;
			end
			bfa_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = bfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfa_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/bfa_dpath.sv
// datapath of the bitmap frame allocator: bitmap memory, frame split,
// word scan, run marking, config registers and result register; uses bfa_pkg
`default_nettype none

`include "bitmap_frame_allocator_assert.svh"

module bfa_dpath #(
	parameter int FRAME_COUNT = 4096,
	parameter int WORD_BITS   = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  bfa_pkg::req_t                     req_payload,
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output bfa_pkg::rsp_t                     rsp_payload,
	input  bfa_pkg::dp_cmd_t                  cmd,
	output bfa_pkg::dp_sts_t                  sts
);

	localparam int STORE_FRAMES = (FRAME_COUNT < bfa_pkg::FRAME_SPAN) ?
		FRAME_COUNT : bfa_pkg::FRAME_SPAN;
	localparam int SW    = (STORE_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (SW > 1) ? $clog2(SW) : 1;
	localparam int WMAX  = (bfa_pkg::FRAME_SPAN + WORD_BITS) / WORD_BITS;
	localparam int WW    = $clog2(WMAX + 1);
	localparam int PW    = $clog2(WORD_BITS);
	localparam int LW    = PW + 1;
	localparam int FBW   = 14;
	localparam int CW    = bfa_pkg::COUNT_W;
	localparam int SHIFT = 20;
	localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PRW   = CW + RW;
	localparam int LIMIT_CAP = STORE_FRAMES;

	// config registers
	logic [CW-1:0] alloc_lo_q;
	logic [CW-1:0] alloc_hi_q;

	// request and search registers
	logic            is_free_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   sf_q;
	logic [PRW-1:0]  prod_s1;
	logic [WW-1:0]   w_q;
	logic [PW-1:0]   p_q;
	logic [FBW-1:0]  fb_q;
	logic [CW-1:0]   run_start_q;
	logic [WW-1:0]   rs_w_q;
	logic [PW-1:0]   rs_p_q;
	logic [CW-1:0]   run_len_q;
	logic [CW-1:0]   rem_q;
	logic [bfa_pkg::FRAME_W-1:0] res_frame_q;
	logic            res_status_q;
	logic            out_valid_q;
	bfa_pkg::rsp_t   out_q;
	logic [AW-1:0]   clr_q;

	// bitmap memory
	logic [WORD_BITS-1:0] mem [SW];
	logic [WORD_BITS-1:0] rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic [AW-1:0]        rd_addr;

	// combinational
	logic [WW-1:0]        loc_w;
	logic [FBW-1:0]       loc_fb;
	logic [PW-1:0]        loc_p;
	logic [FBW-1:0]       lim_frames;
	logic [FBW-1:0]       lim_gap;
	logic [LW-1:0]        lim;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] used_m;
	logic                 found_u;
	logic [PW-1:0]        u;
	logic [LW-1:0]        e;
	logic [LW-1:0]        span;
	logic [FBW-1:0]       reach;
	logic                 hit;
	logic                 fail;
	logic                 u_last;
	logic [LW-1:0]        avail;
	logic [LW-1:0]        len;
	logic [LW-1:0]        end_b;
	logic [WORD_BITS-1:0] mmask;
	logic [WORD_BITS-1:0] wdata;
	logic                 in_store;
	logic [WW-1:0]        w_d;

	// frame number split into word and bit by reciprocal multiply
	always_comb begin
		loc_w  = WW'(prod_s1 >> SHIFT);
		loc_fb = FBW'(loc_w * WORD_BITS);
		loc_p  = PW'({1'b0, sf_q} - loc_fb);
	end

	// scan of one word from the current bit up to the search limit
	always_comb begin
		lim_frames = ({1'b0, alloc_hi_q} < FBW'(LIMIT_CAP)) ?
			{1'b0, alloc_hi_q} : FBW'(LIMIT_CAP);
		lim_gap = lim_frames - fb_q;
		if (lim_frames > fb_q) begin
			lim = (lim_gap >= FBW'(WORD_BITS)) ? LW'(WORD_BITS) : LW'(lim_gap);
		end else begin
			lim = '0;
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			vmask[j] = (LW'(j) >= {1'b0, p_q}) && (LW'(j) < lim);
		end
		used_m  = rd_q & vmask;
		found_u = 1'b0;
		u       = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (used_m[j]) begin
				found_u = 1'b1;
				u       = PW'(j);
			end
		end
		e      = found_u ? {1'b0, u} : lim;
		span   = (e > {1'b0, p_q}) ? (e - {1'b0, p_q}) : '0;
		reach  = {1'b0, run_len_q} + FBW'(span);
		hit    = reach >= {1'b0, cnt_q};
		fail   = !hit && !found_u && (lim < LW'(WORD_BITS));
		u_last = (u == PW'(WORD_BITS - 1));
	end

	// run marking: one word per cycle, set for allocate, clear for free
	always_comb begin
		avail = LW'(WORD_BITS) - {1'b0, p_q};
		len   = (rem_q < CW'(avail)) ? LW'(rem_q) : avail;
		end_b = {1'b0, p_q} + len;
		for (int j = 0; j < WORD_BITS; j++) begin
			mmask[j] = (LW'(j) >= {1'b0, p_q}) && (LW'(j) < end_b);
		end
		wdata    = is_free_q ? (rd_q & ~mmask) : (rd_q | mmask);
		in_store = w_q < WW'(SW);
	end

	// word pointer; the read address follows its next value while that lies in the store, else word 0
	always_comb begin
		w_d = w_q;
		if (cmd.locate) begin
			w_d = loc_w;
		end else if (cmd.scan) begin
			if (hit) w_d = rs_w_q;
			else if (found_u && u_last) w_d = w_q + 1'b1;
			else if (!found_u && !fail) w_d = w_q + 1'b1;
		end else if (cmd.mark) begin
			w_d = w_q + 1'b1;
		end
		rd_addr = (w_d < WW'(SW)) ? w_d[AW-1:0] : '0;
		mem_we  = cmd.clear || (cmd.mark && in_store);
		mem_wa  = cmd.clear ? clr_q : w_q[AW-1:0];
		mem_wd  = cmd.clear ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_lo_q  <= '0;
			alloc_hi_q  <= CW'(4096);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bfa_pkg::CFG_ALLOC_LO: alloc_lo_q <= cfg_data;
					bfa_pkg::CFG_ALLOC_HI: alloc_hi_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.rsp_load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
		if (cmd.capture) begin
			is_free_q    <= (req_payload.cmd == bfa_pkg::CMD_FREE);
			cnt_q        <= req_payload.frame_count;
			sf_q         <= (req_payload.cmd == bfa_pkg::CMD_FREE) ?
				{1'b0, req_payload.first_frame} : alloc_lo_q;
			res_frame_q  <= '0;
			res_status_q <= bfa_pkg::STATUS_OK;
		end
		if (cmd.split) prod_s1 <= PRW'(sf_q) * PRW'(RECIP);
		if (cmd.locate) begin
			p_q         <= loc_p;
			fb_q        <= loc_fb;
			run_start_q <= sf_q;
			rs_w_q      <= loc_w;
			rs_p_q      <= loc_p;
			run_len_q   <= '0;
			rem_q       <= cnt_q;
			if (!is_free_q && cnt_q == '0) res_frame_q <= sf_q[bfa_pkg::FRAME_W-1:0];
		end
		if (cmd.scan) begin
			if (hit) begin
				p_q         <= rs_p_q;
				rem_q       <= cnt_q;
				res_frame_q <= run_start_q[bfa_pkg::FRAME_W-1:0];
			end else if (found_u) begin
				// run broken by a used frame: restart just past it
				run_len_q   <= '0;
				run_start_q <= CW'(fb_q + FBW'(u) + 1'b1);
				if (u_last) begin
					p_q    <= '0;
					fb_q   <= fb_q + FBW'(WORD_BITS);
					rs_w_q <= w_q + 1'b1;
					rs_p_q <= '0;
				end else begin
					p_q    <= u + 1'b1;
					rs_w_q <= w_q;
					rs_p_q <= u + 1'b1;
				end
			end else if (fail) begin
				res_status_q <= bfa_pkg::STATUS_NOMEM;
			end else begin
				run_len_q <= run_len_q + CW'(span);
				p_q       <= '0;
				fb_q      <= fb_q + FBW'(WORD_BITS);
			end
		end
		if (cmd.mark) begin
			p_q   <= '0;
			rem_q <= rem_q - CW'(len);
		end
		if (cmd.rsp_load) begin
			out_q.granted_frame <= res_frame_q;
			out_q.status        <= res_status_q;
		end
	end

	always_comb begin
		sts.clear_done = (clr_q == AW'(SW - 1));
		sts.is_free    = is_free_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.found      = hit;
		sts.fail       = fail;
		sts.mark_last  = (rem_q == CW'(len)) || (w_q >= WW'(SW - 1));
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_payload = out_q;

	`BFA_ASSERT_IMPLIES(a_load_free, clk, arst_n, cmd.rsp_load, !out_valid_q || rsp_ready, "result overwritten")
	`BFA_ASSERT_IMPLIES(a_run_in_range, clk, arst_n, cmd.scan && hit, ({1'b0, run_start_q} + {1'b0, cnt_q}) <= lim_frames, "run past limit")
	`BFA_ASSERT_IMPLIES(a_fail_zero, clk, arst_n, out_valid_q && out_q.status == bfa_pkg::STATUS_NOMEM, out_q.granted_frame == '0, "failed grant not zero")
	`BFA_ASSERT_NEXT(a_scan_forward, clk, arst_n, cmd.scan && !hit, w_q >= $past(w_q), "scan moved backward")

endmodule

`default_nettype wire

### rtl/bitmap_frame_allocator.sv
// top level of the first-fit bitmap frame allocator
// depends on bfa_pkg, bfa_chan_if, bfa_ctrl and bfa_dpath
`default_nettype none

// one bit per frame (set = used) in a single-port-write, registered-read
// memory of WORD_BITS-bit words. after reset the block runs a clearing pass
// that writes one word per cycle until every bitmap word is zero; req.ready
// stays low until it ends while config writes are taken as usual. one request
// is worked at a time. an allocate runs the request transfer, the frame split
// and the word locate, then a first-fit scan that steps through the bitmap
// words and restarts just past each used frame that breaks a candidate run,
// then marks the granted run word by word, and then moves the result into
// the output register once that register is free. a free runs the same setup
// and then marks its run without a scan. a zero-frame request skips both the
// scan and the marking. the bitmap memory port can read one word and write
// one word per cycle. the result register frees the response side, so the
// next request transfer is taken while a result still waits on rsp. the two
// allocation window registers must only be written by the user while the
// block is idle; the block itself does not enforce this.
module bitmap_frame_allocator #(
	parameter int FRAME_COUNT = 4096,
	parameter int WORD_BITS   = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data,
	bfa_chan_if.sink                       req,
	bfa_chan_if.source                     rsp
);

	// command and status between sequencer and datapath
	bfa_pkg::dp_cmd_t dp_cmd;
	bfa_pkg::dp_sts_t dp_sts;
	logic             req_ready;
	logic             rsp_valid;
	bfa_pkg::rsp_t    rsp_payload;

	// sequencer: clearing pass, request transfer, scan, mark, result
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// bitmap, search and result register
	bfa_dpath #(
		.FRAME_COUNT (FRAME_COUNT),
		.WORD_BITS   (WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_payload (req.payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_payload),
		.cmd         (dp_cmd),
		.sts         (dp_sts)
	);

	// channel hookup
	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_payload;

endmodule

`default_nettype wire
